@@ hdl/adsr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants of the ADSR envelope shaper
// Segment codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    SEG_ATTACK  = 2'd0,
    SEG_DECAY   = 2'd1,
    SEG_SUSTAIN = 2'd2,
    SEG_RELEASE = 2'd3
  } seg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_LEN    = 3'd0,
    CFG_ATTACK_STEP   = 3'd1,
    CFG_DECAY_LEN     = 3'd2,
    CFG_DECAY_STEP    = 3'd3,
    CFG_SUSTAIN_LEN   = 3'd4,
    CFG_SUSTAIN_LEVEL = 3'd5,
    CFG_RELEASE_STEP  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } beat_ctl_t;

endpackage : adsr_pkg
`default_nettype wire

@@ hdl/adsr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_front: configuration registers, sample counter and envelope level
// Classifies each input beat into its segment, picks the level it is scaled
// by and advances the envelope state; pushes the beat toward the back end.
// ----------------------------------------------------------------------------
module adsr_front #(
  parameter int COUNT_BITS      = 24,
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int CFG_W           = 24,
  parameter int ENTRY_W         = 35
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]                    cfg_data,
  input  wire logic                                in_valid,
  input  wire logic signed [adsr_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                in_restart,
  output adsr_pkg::beat_ctl_t                      push_ctl,
  input  wire logic                                push_stall,
  output logic [ENTRY_W-1:0]                       push_data
);

  localparam int CW = COUNT_BITS + 2;
  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam logic [LW-1:0] UNITY   = LW'(1) << LEVEL_FRAC_BITS;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [COUNT_BITS-1:0] attack_len_r, decay_len_r, sustain_len_r;
  logic [LW-1:0]         attack_step_r, decay_step_r, sustain_level_r, release_step_r;
  logic [CW-1:0]         cnt_r, cnt_nxt, base_cnt, e1, e2, e3;
  logic [LW-1:0]         lvl_r, lvl_nxt, base_lvl, used, upd;
  logic [LW:0]           add_sum;
  logic [LW-1:0]         atk_cap, dec_cap, sus_cap, rel_cap;
  adsr_pkg::seg_t        seg;
  logic                  accept;

  function automatic logic [LW-1:0] cap_unity(input logic [LW-1:0] v);
    cap_unity = (v > UNITY) ? UNITY : v;
  endfunction

  function automatic logic [LW-1:0] sat_sub(input logic [LW-1:0] a, input logic [LW-1:0] b);
    sat_sub = (b >= a) ? '0 : a - b;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r    <= '0;
      attack_step_r   <= '0;
      decay_len_r     <= '0;
      decay_step_r    <= '0;
      sustain_len_r   <= '0;
      sustain_level_r <= UNITY;
      release_step_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        adsr_pkg::CFG_ATTACK_LEN:    attack_len_r    <= cfg_data[COUNT_BITS-1:0];
        adsr_pkg::CFG_ATTACK_STEP:   attack_step_r   <= cfg_data[LW-1:0];
        adsr_pkg::CFG_DECAY_LEN:     decay_len_r     <= cfg_data[COUNT_BITS-1:0];
        adsr_pkg::CFG_DECAY_STEP:    decay_step_r    <= cfg_data[LW-1:0];
        adsr_pkg::CFG_SUSTAIN_LEN:   sustain_len_r   <= cfg_data[COUNT_BITS-1:0];
        adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_r <= cfg_data[LW-1:0];
        adsr_pkg::CFG_RELEASE_STEP:  release_step_r  <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !push_stall;
  assign base_cnt = in_restart ? '0 : cnt_r;
  assign base_lvl = in_restart ? '0 : lvl_r;
  assign e1       = CW'(attack_len_r);
  assign e2       = e1 + CW'(decay_len_r);
  assign e3       = e2 + CW'(sustain_len_r);
  assign atk_cap  = cap_unity(attack_step_r);
  assign dec_cap  = cap_unity(decay_step_r);
  assign sus_cap  = cap_unity(sustain_level_r);
  assign rel_cap  = cap_unity(release_step_r);
  assign add_sum  = {1'b0, base_lvl} + {1'b0, atk_cap};

  always_comb begin
    if (base_cnt < e1) begin
      seg  = adsr_pkg::SEG_ATTACK;
      used = base_lvl;
      upd  = (add_sum > {1'b0, UNITY}) ? UNITY : add_sum[LW-1:0];
    end else if (base_cnt < e2) begin
      seg  = adsr_pkg::SEG_DECAY;
      used = base_lvl;
      upd  = sat_sub(base_lvl, dec_cap);
    end else if (base_cnt < e3) begin
      seg  = adsr_pkg::SEG_SUSTAIN;
      used = sus_cap;
      upd  = sus_cap;
    end else begin
      seg  = adsr_pkg::SEG_RELEASE;
      used = base_lvl;
      upd  = sat_sub(base_lvl, rel_cap);
    end
  end

  assign cnt_nxt = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + CW'(1);
  assign lvl_nxt = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lvl_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  assign push_ctl.valid = in_valid;
  assign push_ctl.stall = push_stall;
  assign push_data      = {in_sample, used, seg};

`ifndef SYNTHESIS
  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n) lvl_r <= UNITY)
    else $error("envelope level above unity");
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_restart) |=> (cnt_r >= $past(cnt_r)))
    else $error("sample counter went backward without restart");
`endif

endmodule : adsr_front
`default_nettype wire

@@ hdl/adsr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_queue: two-entry queue between front and back end
// Head and tail registers; stall goes high only when both are occupied.
// ----------------------------------------------------------------------------
module adsr_queue #(
  parameter int ENTRY_W = 35
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire adsr_pkg::beat_ctl_t  push_ctl,
  output logic                      push_stall,
  input  wire logic [ENTRY_W-1:0]   push_data,
  output logic                      pop_valid,
  input  wire logic                 pop_stall,
  output logic [ENTRY_W-1:0]        pop_data
);

  logic [1:0]         fill_r, fill_nxt;
  logic [ENTRY_W-1:0] head_r, tail_r;
  logic               push, pop;

  assign push_stall = (fill_r == 2'd2);
  assign push       = push_ctl.valid && !push_ctl.stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = head_r;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_r == 2'd2) begin
      if (pop) begin
        head_r <= tail_r;
      end
    end else if (fill_r == 2'd1) begin
      if (push && pop) begin
        head_r <= push_data;
      end else if (push) begin
        tail_r <= push_data;
      end
    end else if (push) begin
      head_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue fill count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd2 && !pop) |=> (fill_r == 2'd2))
    else $error("full queue lost an entry without a pop");
`endif

endmodule : adsr_queue
`default_nettype wire

@@ hdl/adsr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_back: scaling of a sample by its envelope level
// Signed multiply, floor shift, clamp to 16 bits, then the output register.
// ----------------------------------------------------------------------------
module adsr_back #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int ENTRY_W         = 35
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  pop_valid,
  output logic                                       pop_stall,
  input  wire logic [ENTRY_W-1:0]                    pop_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [adsr_pkg::SAMPLE_W-1:0]       out_shaped,
  output logic [1:0]                                 out_segment
);

  localparam int SW = adsr_pkg::SAMPLE_W;
  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int PW = SW + LW + 1;
  localparam logic signed [PW-1:0] OUT_MAX = PW'(32767);
  localparam logic signed [PW-1:0] OUT_MIN = -PW'(32768);

  logic signed [SW-1:0] smp;
  logic [LW-1:0]        lvl;
  logic [1:0]           seg;
  logic signed [PW-1:0] prod, shifted;
  logic signed [SW-1:0] clamped;
  logic                 out_valid_r, out_valid_nxt, load;
  logic signed [SW-1:0] shaped_r;
  logic [1:0]           segment_r;

  assign smp = pop_data[ENTRY_W-1 -: SW];
  assign lvl = pop_data[LW+1:2];
  assign seg = pop_data[1:0];

  assign prod    = PW'(smp) * $signed({1'b0, lvl});
  assign shifted = prod >>> LEVEL_FRAC_BITS;

  always_comb begin
    if (shifted > OUT_MAX) begin
      clamped = OUT_MAX[SW-1:0];
    end else if (shifted < OUT_MIN) begin
      clamped = OUT_MIN[SW-1:0];
    end else begin
      clamped = shifted[SW-1:0];
    end
  end

  assign pop_stall     = out_valid_r && out_stall;
  assign load          = pop_valid && !pop_stall;
  assign out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shaped_r  <= clamped;
      segment_r <= seg;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_shaped  = shaped_r;
  assign out_segment = segment_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule : adsr_back
`default_nettype wire

@@ hdl/adsr_envelope_shaper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_envelope_shaper: linear ADSR envelope applied to an audio stream
// Front end tracks segment and level, a two-entry queue decouples it from
// the back end, which scales and clamps each sample.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | in_sample, in_restart
//  out_    | output    | out_valid/out_stall| out_shaped, out_segment
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One beat per cycle sustained while out_stall is low; an accepted beat is
//  registered in the queue, then goes through the multiplier to the out reg.
//  The state update (counter compare and level add) is combinational.
//  Reset is synchronous; it clears the queue, output valid, count and level.
//  Output stall backs up the queue; in_stall rises once both entries fill.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module adsr_envelope_shaper #(
  parameter int COUNT_BITS      = 24,
  parameter int LEVEL_FRAC_BITS = 16,
  localparam int CFG_W = (COUNT_BITS > LEVEL_FRAC_BITS + 1) ? COUNT_BITS
                                                           : LEVEL_FRAC_BITS + 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]                      cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [adsr_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                                  in_restart,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [adsr_pkg::SAMPLE_W-1:0]       out_shaped,
  output logic [1:0]                                 out_segment
);

  localparam int ENTRY_W = adsr_pkg::SAMPLE_W + LEVEL_FRAC_BITS + 1 + 2;

  adsr_pkg::beat_ctl_t push_ctl;
  logic                push_stall;
  logic [ENTRY_W-1:0]  push_data;
  logic                pop_valid, pop_stall;
  logic [ENTRY_W-1:0]  pop_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = push_stall;

  adsr_front #(
    .COUNT_BITS      (COUNT_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .CFG_W           (CFG_W),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_sample  (in_sample),
    .in_restart (in_restart),
    .push_ctl   (push_ctl),
    .push_stall (push_stall),
    .push_data  (push_data)
  );

  adsr_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_ctl   (push_ctl),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  adsr_back #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_stall   (pop_stall),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_shaped  (out_shaped),
    .out_segment (out_segment)
  );

endmodule : adsr_envelope_shaper
`default_nettype wire
